// ===== design/arp_pkg.sv =====
`default_nettype none
package arp_pkg;

	localparam int DEF_TABLE_ENTRIES = 8;
	localparam int DEF_QUEUE_DEPTH   = 4;
	localparam int MAX_RESULTS       = 32;

	// configuration register indexes and reset values
	localparam logic [1:0]  CFG_REACHABLE_TIME = 2'd0;
	localparam logic [1:0]  CFG_PROBE_INTERVAL = 2'd1;
	localparam logic [1:0]  CFG_PROBE_LIMIT    = 2'd2;
	localparam logic [31:0] RST_REACHABLE_TIME = 32'd60000;
	localparam logic [31:0] RST_PROBE_INTERVAL = 32'd1000;
	localparam logic [3:0]  RST_PROBE_LIMIT    = 4'd3;

	typedef enum logic [1:0] {
		SLOT_FREE       = 2'd0,
		SLOT_INCOMPLETE = 2'd1,
		SLOT_REACHABLE  = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		REQ_LEARN  = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_SEND   = 2'd2,
		REQ_TICK   = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		RES_NONE     = 3'd0,
		RES_HIT      = 3'd1,
		RES_MISS     = 3'd2,
		RES_TRANSMIT = 3'd3,
		RES_PROBE    = 3'd4,
		RES_RELEASE  = 3'd5
	} res_kind_t;

	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_CREATE = 3'd1,
		OP_LEARN  = 3'd2,
		OP_QPUSH  = 3'd3,
		OP_PROBE  = 3'd4,
		OP_CLEAR  = 3'd5
	} cell_op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FIND, ST_EVICT, ST_EVDEC, ST_ACT, ST_SP, ST_LOOK,
		ST_LRN_RD, ST_LRN_EM, ST_TICK, ST_REL_RD, ST_REL_EM, ST_DONE
	} ctrl_state_t;

	// command broadcast along the cell row
	typedef struct packed {
		cell_op_t    op;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] tval;
	} cell_cmd_t;

	typedef struct packed {
		slot_state_t state;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] expiry;
		logic [31:0] last_probe;
		logic [3:0]  probe_count;
	} cell_view_t;

	// search flags passed from cell to cell
	typedef struct packed {
		logic hit;
		logic free;
	} find_t;

	typedef struct packed {
		res_kind_t   kind;
		logic [47:0] mac;
		logic [31:0] ip;
		logic [15:0] ether_type;
		logic [15:0] handle;
		logic [15:0] length;
	} result_t;

endpackage
`default_nettype wire

// ===== design/arp_if.sv =====
`default_nettype none
interface arp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] ip_addr;
	logic [47:0] mac_addr;
	logic [15:0] ether_type;
	logic [15:0] buffer_handle;
	logic [15:0] packet_length;
	logic [31:0] time_ms;

	modport source(output valid, req_type, ip_addr, mac_addr, ether_type, buffer_handle,
		packet_length, time_ms, input ready);
	modport sink(input valid, req_type, ip_addr, mac_addr, ether_type, buffer_handle,
		packet_length, time_ms, output ready);
endinterface

interface arp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [47:0] mac_out;
	logic [31:0] ip_out;
	logic [15:0] ether_type_out;
	logic [15:0] handle_out;
	logic [15:0] length_out;
	logic        last;

	modport source(output valid, result_kind, mac_out, ip_out, ether_type_out, handle_out,
		length_out, last, input ready);
	modport sink(input valid, result_kind, mac_out, ip_out, ether_type_out, handle_out,
		length_out, last, output ready);
endinterface
`default_nettype wire

// ===== design/arp_ram.sv =====
`default_nettype none
module arp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== design/arp_cell.sv =====
`default_nettype none
module arp_cell #(
	parameter int TABLE_ENTRIES = arp_pkg::DEF_TABLE_ENTRIES,
	parameter int QUEUE_DEPTH   = arp_pkg::DEF_QUEUE_DEPTH,
	parameter int IDX           = 0,
	localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int QCW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire arp_pkg::cell_cmd_t cmd,
	input  wire logic [IW-1:0]     cmd_idx,
	input  wire arp_pkg::find_t    fnd_i,
	input  wire logic [IW-1:0]     hit_idx_i,
	input  wire logic [IW-1:0]     free_idx_i,
	output arp_pkg::find_t         fnd_o,
	output logic      [IW-1:0]     hit_idx_o,
	output logic      [IW-1:0]     free_idx_o,
	output arp_pkg::cell_view_t    view,
	output logic      [QCW-1:0]    qcount
);
	arp_pkg::slot_state_t state_q;
	logic [31:0]    ip_q;
	logic [47:0]    mac_q;
	logic [31:0]    exp_q;
	logic [31:0]    lp_q;
	logic [3:0]     pc_q;
	logic [QCW-1:0] qc_q;
	logic           sel;
	logic           my_hit;
	logic           my_free;

	assign sel = (cmd_idx == IW'(IDX));

	// search chain: the first matching cell wins
	assign my_hit  = (state_q != arp_pkg::SLOT_FREE) && (ip_q == cmd.ip);
	assign my_free = (state_q == arp_pkg::SLOT_FREE);
	assign fnd_o.hit  = fnd_i.hit | my_hit;
	assign fnd_o.free = fnd_i.free | my_free;
	assign hit_idx_o  = fnd_i.hit ? hit_idx_i : IW'(IDX);
	assign free_idx_o = fnd_i.free ? free_idx_i : IW'(IDX);

	assign view.state       = state_q;
	assign view.ip          = ip_q;
	assign view.mac         = mac_q;
	assign view.expiry      = exp_q;
	assign view.last_probe  = lp_q;
	assign view.probe_count = pc_q;
	assign qcount           = qc_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arp_pkg::SLOT_FREE;
			pc_q    <= '0;
			qc_q    <= '0;
		end else if (sel) begin
			case (cmd.op)
				arp_pkg::OP_CREATE: begin
					state_q <= arp_pkg::SLOT_INCOMPLETE;
					pc_q    <= '0;
					qc_q    <= '0;
				end
				arp_pkg::OP_LEARN: begin
					state_q <= arp_pkg::SLOT_REACHABLE;
					if (state_q != arp_pkg::SLOT_REACHABLE) begin
						qc_q <= '0;
					end
				end
				arp_pkg::OP_QPUSH: qc_q <= qc_q + 1'b1;
				arp_pkg::OP_PROBE: pc_q <= pc_q + 1'b1;
				arp_pkg::OP_CLEAR: begin
					state_q <= arp_pkg::SLOT_FREE;
					pc_q    <= '0;
					qc_q    <= '0;
				end
				default: ;
			endcase
		end
	end

	// binding payload
	always_ff @(posedge clk) begin
		if (sel) begin
			case (cmd.op)
				arp_pkg::OP_CREATE: begin
					ip_q  <= cmd.ip;
					exp_q <= '0;
					lp_q  <= '0;
				end
				arp_pkg::OP_LEARN: begin
					mac_q <= cmd.mac;
					exp_q <= cmd.tval;
				end
				arp_pkg::OP_PROBE: lp_q <= cmd.tval;
				arp_pkg::OP_CLEAR: begin
					exp_q <= '0;
					lp_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	a_qc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qc_q <= QCW'(QUEUE_DEPTH)) else $error("queue count past depth");
	a_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == arp_pkg::SLOT_FREE |-> qc_q == '0 && pc_q == '0)
		else $error("free slot holds queue or probe state");
endmodule
`default_nettype wire

// ===== design/arp_neighbor_cache.sv =====
// Address-resolution neighbor cache.
// Requests arrive as beats on req (learn, lookup, send-or-queue, tick) and
// each produces one or more result beats on res; the final beat of a request
// carries last. A request with no event answers with one beat of kind none.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle; the block does not enforce it.
// One request is worked at a time; req.ready is high only while idle.
// The eviction and tick scans visit one cell per cycle (the tick scan only
// while the result path can take a beat); each queued frame released is read
// from the one-read-port queue memory and then emitted.
// Results pass through a staging register and an output register, so a
// stalled receiver only holds the work once both are full; no beat is lost.
// Reset (arst_n low) frees all slots and loads default configuration; no
// memory clearing pass is needed.
`default_nettype none
module arp_neighbor_cache #(
	parameter int TABLE_ENTRIES = arp_pkg::DEF_TABLE_ENTRIES,
	parameter int QUEUE_DEPTH   = arp_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	arp_req_if.sink          req,
	arp_res_if.source        res,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int QD_ENTRIES = TABLE_ENTRIES * QUEUE_DEPTH;
	localparam int AW  = (QD_ENTRIES > 1) ? $clog2(QD_ENTRIES) : 1;
	localparam int NW  = $clog2(arp_pkg::MAX_RESULTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	// configuration
	logic [31:0] rt_q, pi_q;
	logic [3:0]  pl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q <= arp_pkg::RST_REACHABLE_TIME;
			pi_q <= arp_pkg::RST_PROBE_INTERVAL;
			pl_q <= arp_pkg::RST_PROBE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				arp_pkg::CFG_REACHABLE_TIME: rt_q <= cfg_data;
				arp_pkg::CFG_PROBE_INTERVAL: pi_q <= cfg_data;
				arp_pkg::CFG_PROBE_LIMIT:    pl_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	arp_pkg::ctrl_state_t st_q, nxt;
	arp_pkg::req_kind_t   rk_q;
	logic [31:0] ip_q, now_q;
	logic [47:0] mac_q;
	logic [15:0] et_q, h_q, len_q;
	logic [IW-1:0]  s_q, s_d, i_q, i_d, best_q, best_d;
	logic [31:0]    bexp_q, bexp_d;
	logic           bv_q, bv_d;
	logic [QCW-1:0] q_q, q_d, cnt_q, cnt_d;
	logic [NW-1:0]  n_q, n_d;
	logic           acc;

	// result staging and output register
	arp_pkg::result_t pend_q, out_q, gen;
	logic pend_valid_q, out_valid_q, out_last_q;
	logic emit, done_push, can_push, emit_ok;

	// cell row
	arp_pkg::cell_cmd_t  cmd;
	logic [IW-1:0]       cmd_idx;
	arp_pkg::find_t      fnd [TABLE_ENTRIES+1];
	logic [IW-1:0]       hit_idx [TABLE_ENTRIES+1];
	logic [IW-1:0]       free_idx [TABLE_ENTRIES+1];
	arp_pkg::cell_view_t views [TABLE_ENTRIES];
	logic [QCW-1:0]      qcs [TABLE_ENTRIES];
	arp_pkg::cell_view_t view;
	logic [QCW-1:0]      qcv;
	logic [IW-1:0]       vidx;

	assign fnd[0]      = '0;
	assign hit_idx[0]  = '0;
	assign free_idx[0] = '0;

	for (genvar c = 0; c < TABLE_ENTRIES; c++) begin : g_cell
		arp_cell #(
			.TABLE_ENTRIES(TABLE_ENTRIES),
			.QUEUE_DEPTH(QUEUE_DEPTH),
			.IDX(c)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_idx(cmd_idx),
			.fnd_i(fnd[c]), .hit_idx_i(hit_idx[c]), .free_idx_i(free_idx[c]),
			.fnd_o(fnd[c+1]), .hit_idx_o(hit_idx[c+1]), .free_idx_o(free_idx[c+1]),
			.view(views[c]), .qcount(qcs[c])
		);
	end

	assign view = views[vidx];
	assign qcv  = qcs[vidx];

	// queued frames: {handle, ethertype, length}
	logic          wr_en;
	logic [AW-1:0] waddr, raddr;
	logic [47:0]   rdata;

	assign waddr = AW'(s_q) * AW'(QUEUE_DEPTH) + AW'(qcv);
	assign raddr = AW'(s_q) * AW'(QUEUE_DEPTH) + AW'(q_q);

	arp_ram #(.WIDTH(48), .DEPTH(QD_ENTRIES)) u_qram (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata({h_q, et_q, len_q}),
		.raddr(raddr), .rdata(rdata)
	);

	assign acc      = req.valid && req.ready;
	assign can_push = !out_valid_q || res.ready;
	assign emit_ok  = !pend_valid_q || can_push;
	assign req.ready = (st_q == arp_pkg::ST_IDLE);

	// time tests on wrapping signed differences
	logic [31:0] d_exp, d_lp, d_now_exp;
	logic        due, expired, retry, over;
	logic [NW:0] need_sum;

	assign d_exp     = view.expiry - bexp_q;
	assign d_lp      = now_q - view.last_probe;
	assign d_now_exp = now_q - view.expiry;
	assign due       = !d_lp[31] && (d_lp >= pi_q);
	assign expired   = !d_now_exp[31];
	assign retry     = view.probe_count < pl_q;
	assign need_sum  = {1'b0, n_q} + (retry ? (NW+1)'(1) : (NW+1)'(qcv));
	assign over      = need_sum > (NW+1)'(arp_pkg::MAX_RESULTS);

	// sequencer: next state, cell commands and result generation
	always_comb begin
		nxt       = st_q;
		s_d       = s_q;
		i_d       = i_q;
		best_d    = best_q;
		bexp_d    = bexp_q;
		bv_d      = bv_q;
		q_d       = q_q;
		cnt_d     = cnt_q;
		n_d       = n_q;
		cmd.op    = arp_pkg::OP_NONE;
		cmd.ip    = ip_q;
		cmd.mac   = mac_q;
		cmd.tval  = now_q;
		cmd_idx   = s_q;
		vidx      = s_q;
		emit      = 1'b0;
		gen       = '0;
		done_push = 1'b0;
		wr_en     = 1'b0;
		case (st_q)
			arp_pkg::ST_IDLE: begin
				if (acc) begin
					i_d = '0;
					n_d = '0;
					case (arp_pkg::req_kind_t'(req.req_type))
						arp_pkg::REQ_LOOKUP: nxt = arp_pkg::ST_LOOK;
						arp_pkg::REQ_TICK:   nxt = arp_pkg::ST_TICK;
						default:             nxt = arp_pkg::ST_FIND;
					endcase
				end
			end
			arp_pkg::ST_FIND: begin
				if (fnd[TABLE_ENTRIES].hit) begin
					s_d = hit_idx[TABLE_ENTRIES];
					nxt = arp_pkg::ST_ACT;
				end else if (fnd[TABLE_ENTRIES].free) begin
					s_d     = free_idx[TABLE_ENTRIES];
					cmd.op  = arp_pkg::OP_CREATE;
					cmd_idx = free_idx[TABLE_ENTRIES];
					nxt     = arp_pkg::ST_ACT;
				end else begin
					i_d  = '0;
					bv_d = 1'b0;
					nxt  = arp_pkg::ST_EVICT;
				end
			end
			arp_pkg::ST_EVICT: begin
				vidx = i_q;
				if (view.state == arp_pkg::SLOT_REACHABLE && (!bv_q || d_exp[31])) begin
					best_d = i_q;
					bexp_d = view.expiry;
					bv_d   = 1'b1;
				end
				if (i_q == LAST_IDX) begin
					nxt = arp_pkg::ST_EVDEC;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			arp_pkg::ST_EVDEC: begin
				if (bv_q) begin
					s_d     = best_q;
					cmd.op  = arp_pkg::OP_CREATE;
					cmd_idx = best_q;
					nxt     = arp_pkg::ST_ACT;
				end else if (rk_q == arp_pkg::REQ_LEARN) begin
					nxt = arp_pkg::ST_DONE;
				end else if (emit_ok) begin
					emit       = 1'b1;
					gen.kind   = arp_pkg::RES_RELEASE;
					gen.handle = h_q;
					nxt        = arp_pkg::ST_DONE;
				end
			end
			arp_pkg::ST_ACT: begin
				if (rk_q == arp_pkg::REQ_LEARN) begin
					cmd.op   = arp_pkg::OP_LEARN;
					cmd.tval = now_q + rt_q;
					cnt_d    = qcv;
					q_d      = '0;
					if (view.state != arp_pkg::SLOT_REACHABLE && qcv != '0) begin
						nxt = arp_pkg::ST_LRN_RD;
					end else begin
						nxt = arp_pkg::ST_DONE;
					end
				end else if (emit_ok) begin
					if (view.state == arp_pkg::SLOT_REACHABLE) begin
						emit           = 1'b1;
						gen.kind       = arp_pkg::RES_TRANSMIT;
						gen.mac        = view.mac;
						gen.ether_type = et_q;
						gen.handle     = h_q;
						gen.length     = len_q;
						nxt            = arp_pkg::ST_DONE;
					end else begin
						if (qcv < QCW'(QUEUE_DEPTH)) begin
							wr_en  = 1'b1;
							cmd.op = arp_pkg::OP_QPUSH;
						end else begin
							emit       = 1'b1;
							gen.kind   = arp_pkg::RES_RELEASE;
							gen.handle = h_q;
						end
						nxt = arp_pkg::ST_SP;
					end
				end
			end
			arp_pkg::ST_SP: begin
				if (view.probe_count != '0) begin
					nxt = arp_pkg::ST_DONE;
				end else if (emit_ok) begin
					emit     = 1'b1;
					gen.kind = arp_pkg::RES_PROBE;
					gen.ip   = ip_q;
					cmd.op   = arp_pkg::OP_PROBE;
					nxt      = arp_pkg::ST_DONE;
				end
			end
			arp_pkg::ST_LOOK: begin
				vidx = hit_idx[TABLE_ENTRIES];
				if (emit_ok) begin
					emit = 1'b1;
					if (fnd[TABLE_ENTRIES].hit && view.state == arp_pkg::SLOT_REACHABLE) begin
						gen.kind = arp_pkg::RES_HIT;
						gen.mac  = view.mac;
					end else begin
						gen.kind = arp_pkg::RES_MISS;
					end
					nxt = arp_pkg::ST_DONE;
				end
			end
			arp_pkg::ST_LRN_RD: nxt = arp_pkg::ST_LRN_EM;
			arp_pkg::ST_LRN_EM: begin
				if (emit_ok) begin
					emit           = 1'b1;
					gen.kind       = arp_pkg::RES_TRANSMIT;
					gen.mac        = mac_q;
					gen.handle     = rdata[47:32];
					gen.ether_type = rdata[31:16];
					gen.length     = rdata[15:0];
					q_d            = q_q + 1'b1;
					nxt = (q_d == cnt_q) ? arp_pkg::ST_DONE : arp_pkg::ST_LRN_RD;
				end
			end
			arp_pkg::ST_TICK: begin
				vidx    = i_q;
				cmd_idx = i_q;
				if (emit_ok) begin
					// default: move on to the next slot
					nxt = (i_q == LAST_IDX) ? arp_pkg::ST_DONE : arp_pkg::ST_TICK;
					if (i_q != LAST_IDX) begin
						i_d = i_q + 1'b1;
					end
					case (view.state)
						arp_pkg::SLOT_INCOMPLETE: begin
							if (due) begin
								if (over) begin
									nxt = arp_pkg::ST_DONE;
									i_d = i_q;
								end else if (retry) begin
									emit     = 1'b1;
									gen.kind = arp_pkg::RES_PROBE;
									gen.ip   = view.ip;
									cmd.op   = arp_pkg::OP_PROBE;
									n_d      = n_q + 1'b1;
								end else if (qcv == '0) begin
									cmd.op = arp_pkg::OP_CLEAR;
								end else begin
									s_d   = i_q;
									cnt_d = qcv;
									q_d   = '0;
									i_d   = i_q;
									nxt   = arp_pkg::ST_REL_RD;
								end
							end
						end
						arp_pkg::SLOT_REACHABLE: begin
							if (expired) begin
								cmd.op = arp_pkg::OP_CLEAR;
							end
						end
						default: ;
					endcase
				end
			end
			arp_pkg::ST_REL_RD: nxt = arp_pkg::ST_REL_EM;
			arp_pkg::ST_REL_EM: begin
				if (emit_ok) begin
					emit       = 1'b1;
					gen.kind   = arp_pkg::RES_RELEASE;
					gen.handle = rdata[47:32];
					n_d        = n_q + 1'b1;
					q_d        = q_q + 1'b1;
					if (q_d == cnt_q) begin
						cmd.op = arp_pkg::OP_CLEAR;
						if (i_q == LAST_IDX) begin
							nxt = arp_pkg::ST_DONE;
						end else begin
							i_d = i_q + 1'b1;
							nxt = arp_pkg::ST_TICK;
						end
					end else begin
						nxt = arp_pkg::ST_REL_RD;
					end
				end
			end
			arp_pkg::ST_DONE: begin
				if (can_push) begin
					done_push = 1'b1;
					nxt       = arp_pkg::ST_IDLE;
				end
			end
			default: nxt = arp_pkg::ST_IDLE;
		endcase
	end

	// state register and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= arp_pkg::ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			n_q          <= '0;
			bv_q         <= 1'b0;
		end else begin
			st_q <= nxt;
			n_q  <= n_d;
			bv_q <= bv_d;
			if (done_push) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (emit) begin
				pend_valid_q <= 1'b1;
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end else if (res.ready) begin
					out_valid_q <= 1'b0;
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request fields, scan registers and result payload
	always_ff @(posedge clk) begin
		s_q    <= s_d;
		i_q    <= i_d;
		best_q <= best_d;
		bexp_q <= bexp_d;
		q_q    <= q_d;
		cnt_q  <= cnt_d;
		if (acc) begin
			rk_q  <= arp_pkg::req_kind_t'(req.req_type);
			ip_q  <= req.ip_addr;
			mac_q <= req.mac_addr;
			et_q  <= req.ether_type;
			h_q   <= req.buffer_handle;
			len_q <= req.packet_length;
			now_q <= req.time_ms;
		end
		if (done_push) begin
			out_q      <= pend_valid_q ? pend_q : '0;
			out_last_q <= 1'b1;
		end else if (emit) begin
			pend_q <= gen;
			if (pend_valid_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end
	end

	assign res.valid          = out_valid_q;
	assign res.result_kind    = out_q.kind;
	assign res.mac_out        = out_q.mac;
	assign res.ip_out         = out_q.ip;
	assign res.ether_type_out = out_q.ether_type;
	assign res.handle_out     = out_q.handle;
	assign res.length_out     = out_q.length;
	assign res.last           = out_last_q;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == arp_pkg::ST_IDLE |-> !pend_valid_q) else $error("staged beat left in idle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(arp_pkg::MAX_RESULTS)) else $error("result count past limit");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> st_q != arp_pkg::ST_IDLE) else $error("accepted request not worked");
endmodule
`default_nettype wire
